@@ sv/fmrc_pkg.sv @@
// ---------------------------------------------------------------------------
// fmrc_pkg
// Shared types and constants of the framed message ring with commit/rollback.
// ---------------------------------------------------------------------------
package fmrc_pkg;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_DATA      = 3'd1,
		CMD_COMMIT    = 3'd2,
		CMD_ROLLBACK  = 3'd3,
		CMD_CLEAR     = 3'd4,
		CMD_READ_REQ  = 3'd5,
		CMD_READ_BYTE = 3'd6
	} cmd_t;

	// Free bytes needed to reopen the endpoint: prefix plus one packet.
	localparam logic [15:0] ACCEPT_RESET = 16'd66;

	// Input item, last field in the lowest bits.
	typedef struct packed {
		logic [15:0] max_length;
		logic [7:0]  data_byte;
		logic [31:0] transfer_size;
		cmd_t        command;
	} in_item_t;

	// Result item without the last marker, last field in the lowest bits.
	typedef struct packed {
		logic [15:0] stored_bytes;
		logic        endpoint_open;
		logic [7:0]  read_data;
		logic [15:0] message_length;
		logic        accepted;
	} out_item_t;

	localparam int IN_ITEM_W  = $bits(in_item_t);
	localparam int OUT_ITEM_W = $bits(out_item_t);
	localparam int OUT_DATA_W = 48;

	// Controller to datapath commands.
	typedef struct packed {
		logic accept;
		logic exec;
		logic wr2;
		logic peek_a;
		logic peek_b;
		logic load;
	} dp_ctrl_t;

endpackage

@@ sv/framed_message_ring_commit_rollback_unit.sv @@
// ---------------------------------------------------------------------------
// framed_message_ring_commit_rollback_unit
// Receive byte ring of length-prefixed messages with commit and rollback.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake               Content
// s_axis    in   tvalid/tready           one command item
// m_axis    out  tvalid/tready, tlast    one status/result item per command
// cfg       in   cfg_wr_en               accept_threshold
//
// Each item runs from its accept through execute with the first ring write,
// the second prefix write, two registered reads of the next length prefix
// from the ring, then the result load. The result register and its valid
// flag are loaded together in that load step.
// The next item is accepted while a result still waits on m_axis; its load
// then holds until the waiting result is taken.
// Ring contents are undefined after reset; no clearing pass is run.
// Write accept_threshold only while the block is idle.
// ---------------------------------------------------------------------------
module framed_message_ring_commit_rollback_unit #(
	parameter int RING_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] command, [34:3] transfer_size, [42:35] data_byte, [58:43] max_length
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] accepted, [16:1] message_length, [24:17] read_data,
	// [25] endpoint_open, [41:26] stored_bytes
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import fmrc_pkg::*;

	dp_ctrl_t  ctrl;
	in_item_t  item;
	out_item_t result;

	assign item         = in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
	assign m_axis_tdata = {{(OUT_DATA_W - OUT_ITEM_W){1'b0}}, result};

	fmrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctrl      (ctrl)
	);

	fmrc_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.item        (item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.result      (result),
		.result_last (m_axis_tlast)
	);

endmodule

@@ sv/fmrc_ctrl.sv @@
// ---------------------------------------------------------------------------
// fmrc_ctrl
// Sequencer: execute, second write, prefix reads, result load; out handshake.
// ---------------------------------------------------------------------------
module fmrc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output fmrc_pkg::dp_ctrl_t ctrl
);
	import fmrc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_WR2    = 6'b000100,
		S_PEEK_A = 6'b001000,
		S_PEEK_B = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	assign ctrl.accept = in_valid && in_ready;
	assign ctrl.exec   = (state_q == S_EXEC);
	assign ctrl.wr2    = (state_q == S_WR2);
	assign ctrl.peek_a = (state_q == S_PEEK_A);
	assign ctrl.peek_b = (state_q == S_PEEK_B);
	assign ctrl.load   = load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_EXEC;
			S_EXEC:   state_d = S_WR2;
			S_WR2:    state_d = S_PEEK_A;
			S_PEEK_A: state_d = S_PEEK_B;
			S_PEEK_B: state_d = S_FINISH;
			S_FINISH: if (load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_rise_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result valid rose without a load");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept |=> state_q == S_EXEC)
		else $error("accepted item not executed");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) && out_valid_q && !out_ready |=> state_q == S_FINISH)
		else $error("result loaded over a waiting one");

endmodule

@@ sv/fmrc_datapath.sv @@
// ---------------------------------------------------------------------------
// fmrc_datapath
// Ring memory, pointers, counters and result register of the message ring.
// ---------------------------------------------------------------------------
module fmrc_datapath #(
	parameter int RING_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fmrc_pkg::dp_ctrl_t  ctrl,
	input  fmrc_pkg::in_item_t  item,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	output fmrc_pkg::out_item_t result,
	output logic                result_last
);
	import fmrc_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);
	localparam int EW = PW + 1;
	localparam logic [EW-1:0] DEPTH_E = EW'(RING_DEPTH);

	typedef logic [PW-1:0] ptr_t;

	function automatic ptr_t ring_add(ptr_t p, logic [1:0] n);
		logic [EW-1:0] s;
		s = {1'b0, p} + EW'(n);
		if (s >= DEPTH_E) s = s - DEPTH_E;
		return s[PW-1:0];
	endfunction

	function automatic ptr_t ring_sub(ptr_t a, ptr_t b);
		logic [EW-1:0] s;
		if (a >= b) s = {1'b0, a} - {1'b0, b};
		else        s = {1'b0, a} + DEPTH_E - {1'b0, b};
		return s[PW-1:0];
	endfunction

	logic [7:0] ring_mem [RING_DEPTH];

	in_item_t    item_q;
	ptr_t        wp_q, cp_q, rp_q, pp_q, committed_q;
	logic        receiving_q, held_q;
	logic [15:0] pop_q, thr_q;
	logic [15:0] raw_len_q;
	logic [7:0]  rd_q, lo_q;
	ptr_t        wr2_addr_q;
	logic [7:0]  wr2_data_q;
	logic        wr2_en_q, hold_eval_q;
	logic        res_acc_q, res_len_set_q, res_last_q;
	logic [15:0] res_len_q;
	logic [7:0]  res_rdata_q;

	ptr_t        used, free_sp, commit_len, rd_addr, wr_addr;
	logic [15:0] commit_len16;
	logic        wr_en;
	logic [7:0]  wr_data;

	ptr_t        wp_d, cp_d, rp_d, pp_d, committed_d, wr1_addr, wr2_addr_d;
	logic        receiving_d, wr1_en, wr2_en_d, hold_eval_d, clear_d;
	logic [7:0]  wr1_data, wr2_data_d, rdata_d;
	logic [15:0] pop_d, len_d;
	logic        acc_d, len_set_d, last_d;
	logic [15:0] peek;

	assign used         = ring_sub(wp_q, rp_q);
	assign free_sp      = ptr_t'(RING_DEPTH - 1) - used;
	assign commit_len   = ring_sub(ring_sub(wp_q, pp_q), ptr_t'(2));
	assign commit_len16 = 16'(commit_len);

	always_comb begin
		wp_d        = wp_q;
		cp_d        = cp_q;
		rp_d        = rp_q;
		pp_d        = pp_q;
		committed_d = committed_q;
		receiving_d = receiving_q;
		pop_d       = pop_q;
		wr1_en      = 1'b0;
		wr1_addr    = wp_q;
		wr1_data    = 8'd0;
		wr2_en_d    = 1'b0;
		wr2_addr_d  = ring_add(wp_q, 2'd1);
		wr2_data_d  = 8'd0;
		acc_d       = 1'b0;
		len_set_d   = 1'b0;
		len_d       = 16'd0;
		rdata_d     = 8'd0;
		last_d      = 1'b0;
		hold_eval_d = 1'b0;
		clear_d     = 1'b0;
		case (item_q.command)
			CMD_START: begin
				if (!receiving_q) begin
					if (({1'b0, item_q.transfer_size} + 33'd2) <= 33'(free_sp)) begin
						// reserve the length prefix as two zero bytes
						acc_d       = 1'b1;
						pp_d        = wp_q;
						wr1_en      = 1'b1;
						wr2_en_d    = 1'b1;
						wp_d        = ring_add(wp_q, 2'd2);
						receiving_d = 1'b1;
					end
				end else if ({1'b0, item_q.transfer_size} <= 33'(free_sp)) begin
					acc_d = 1'b1;
				end
			end
			CMD_DATA: begin
				if (receiving_q && (free_sp != '0)) begin
					wr1_en   = 1'b1;
					wr1_data = item_q.data_byte;
					wp_d     = ring_add(wp_q, 2'd1);
				end
				hold_eval_d = 1'b1;
			end
			CMD_COMMIT: begin
				if (receiving_q) begin
					// fill in the prefix, little endian
					wr1_en      = 1'b1;
					wr1_addr    = pp_q;
					wr1_data    = commit_len16[7:0];
					wr2_en_d    = 1'b1;
					wr2_addr_d  = ring_add(pp_q, 2'd1);
					wr2_data_d  = commit_len16[15:8];
					cp_d        = wp_q;
					committed_d = committed_q + commit_len + ptr_t'(2);
					receiving_d = 1'b0;
				end
				hold_eval_d = 1'b1;
			end
			CMD_ROLLBACK: begin
				if (receiving_q) begin
					wp_d        = cp_q;
					receiving_d = 1'b0;
				end
				hold_eval_d = 1'b1;
			end
			CMD_CLEAR: begin
				wp_d        = '0;
				cp_d        = '0;
				rp_d        = '0;
				committed_d = '0;
				receiving_d = 1'b0;
				pop_d       = 16'd0;
				clear_d     = 1'b1;
			end
			CMD_READ_REQ: begin
				len_set_d = 1'b1;
				if ((pop_q == 16'd0) && (committed_q >= ptr_t'(2))) begin
					if ((raw_len_q <= item_q.max_length) &&
					    (17'(committed_q) >= (17'(raw_len_q) + 17'd2))) begin
						acc_d       = 1'b1;
						len_d       = raw_len_q;
						rp_d        = ring_add(rp_q, 2'd2);
						committed_d = committed_q - ptr_t'(2);
						pop_d       = raw_len_q;
					end
				end
				hold_eval_d = held_q;
			end
			CMD_READ_BYTE: begin
				if ((pop_q != 16'd0) && (committed_q != '0)) begin
					// head byte was captured with the last prefix read
					rdata_d     = raw_len_q[7:0];
					rp_d        = ring_add(rp_q, 2'd1);
					committed_d = committed_q - ptr_t'(1);
					pop_d       = pop_q - 16'd1;
					if (pop_q == 16'd1) begin
						last_d      = 1'b1;
						hold_eval_d = held_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign wr_en   = (ctrl.exec && wr1_en) || (ctrl.wr2 && wr2_en_q);
	assign wr_addr = ctrl.wr2 ? wr2_addr_q : wr1_addr;
	assign wr_data = ctrl.wr2 ? wr2_data_q : wr1_data;
	assign rd_addr = ctrl.peek_b ? ring_add(rp_q, 2'd1) : rp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= wr_data;
		end
		if (ctrl.peek_a || ctrl.peek_b) begin
			rd_q <= ring_mem[rd_addr];
		end
	end

	assign peek = ((committed_q != '0) && (pop_q == 16'd0)) ? {rd_q, lo_q} : 16'd0;

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			item_q <= item;
		end
		if (ctrl.exec) begin
			wr2_addr_q    <= wr2_addr_d;
			wr2_data_q    <= wr2_data_d;
			res_acc_q     <= acc_d;
			res_len_set_q <= len_set_d;
			res_len_q     <= len_d;
			res_rdata_q   <= rdata_d;
			res_last_q    <= last_d;
		end
		if (ctrl.peek_b) begin
			lo_q <= rd_q;
		end
		if (ctrl.load) begin
			raw_len_q             <= {rd_q, lo_q};
			result.accepted       <= res_acc_q;
			result.message_length <= res_len_set_q ? res_len_q : peek;
			result.read_data      <= res_rdata_q;
			result.endpoint_open  <= !held_q;
			result.stored_bytes   <= 16'(committed_q);
			result_last           <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			cp_q        <= '0;
			rp_q        <= '0;
			pp_q        <= '0;
			committed_q <= '0;
			receiving_q <= 1'b0;
			held_q      <= 1'b0;
			pop_q       <= 16'd0;
			thr_q       <= ACCEPT_RESET;
			wr2_en_q    <= 1'b0;
			hold_eval_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (ctrl.exec) begin
				wp_q        <= wp_d;
				cp_q        <= cp_d;
				rp_q        <= rp_d;
				pp_q        <= pp_d;
				committed_q <= committed_d;
				receiving_q <= receiving_d;
				pop_q       <= pop_d;
				wr2_en_q    <= wr2_en_d;
				hold_eval_q <= hold_eval_d;
				if (clear_d) begin
					held_q <= 1'b0;
				end
			end
			// re-evaluate the hold against the updated pointers
			if (ctrl.peek_a && hold_eval_q) begin
				held_q <= 17'(free_sp) < 17'(thr_q);
			end
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!receiving_q |-> wp_q == cp_q)
		else $error("write pointer ahead of commit pointer outside a message");

	a_pop_covered: assert property (@(posedge clk) disable iff (!arst_n)
		17'(pop_q) <= 17'(committed_q))
		else $error("pop count exceeds committed bytes");

	a_committed_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		committed_q <= used)
		else $error("committed bytes exceed occupied ring space");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed message ring. Command items go in on
// s_axis, one status item per command comes back on m_axis. A small
// scoreboard keeps its own copy of the ring, pointers and hold flag, predicts
// every status item and compares it field by field. Both sides idle at
// random, and the reader backs off once for a long stretch so the ring
// control stalls its input.
// ---------------------------------------------------------------------------
module tb_top;
	import fmrc_pkg::*;

	localparam int          RING_DEPTH      = 1024;
	localparam bit [2:0]    CMD_UNKNOWN     = 3'd7;
	localparam int unsigned PRESSURE_CYCLES = 400;
	localparam int unsigned PRESSURE_AFTER  = 500;
	localparam int unsigned WATCHDOG_LIMIT  = 3000;
	localparam int unsigned DRAIN_CYCLES    = 20;
	localparam int unsigned PHASE_ITEMS     = 25;

	typedef struct packed {
		bit        accepted;
		bit [15:0] message_length;
		bit [7:0]  read_data;
		bit        last_byte;
		bit        endpoint_open;
		bit [15:0] stored_bytes;
	} ring_status_t;

	class message_ring_checker;
		ring_status_t pending_status[$];
		bit [7:0]     ring_bytes[RING_DEPTH];
		int unsigned  wr_ptr, commit_ptr, rd_ptr, prefix_pos;
		int unsigned  committed, pop_left;
		bit           receiving, held;
		bit [15:0]    threshold;
		int unsigned  failures;

		function new();
			wr_ptr = 0;
			commit_ptr = 0;
			rd_ptr = 0;
			prefix_pos = 0;
			committed = 0;
			pop_left = 0;
			receiving = 1'b0;
			held = 1'b0;
			threshold = ACCEPT_RESET;
			failures = 0;
		endfunction

		function int unsigned free_bytes();
			return RING_DEPTH - 1 - ((wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH);
		endfunction

		function void restart_check();
			held = free_bytes() < threshold;
		endfunction

		function bit [15:0] next_length();
			if (committed == 0 || pop_left != 0)
				return 16'd0;
			return {ring_bytes[(rd_ptr + 1) % RING_DEPTH], ring_bytes[rd_ptr]};
		endfunction

		// Predict the status item of one accepted command and queue it.
		function void note_command(bit [63:0] tdata);
			bit [2:0]          cmd;
			bit [31:0]         size;
			bit [7:0]          data_in;
			bit [15:0]         limit;
			longint unsigned   need;
			int unsigned       mlen;
			bit                length_set;
			ring_status_t      st;
			cmd = tdata[2:0];
			size = tdata[34:3];
			data_in = tdata[42:35];
			limit = tdata[58:43];
			length_set = 1'b0;
			st = '0;
			case (cmd)
				CMD_START: begin
					if (!receiving) begin
						need = size;
						need += 2;
						if (need <= free_bytes()) begin
							st.accepted = 1'b1;
							prefix_pos = wr_ptr;
							ring_bytes[wr_ptr] = 8'd0;
							ring_bytes[(wr_ptr + 1) % RING_DEPTH] = 8'd0;
							wr_ptr = (wr_ptr + 2) % RING_DEPTH;
							receiving = 1'b1;
						end
					end else if (size <= free_bytes()) begin
						// continuation: no new prefix
						st.accepted = 1'b1;
					end
				end
				CMD_DATA: begin
					if (receiving && free_bytes() >= 1) begin
						ring_bytes[wr_ptr] = data_in;
						wr_ptr = (wr_ptr + 1) % RING_DEPTH;
					end
					restart_check();
				end
				CMD_COMMIT: begin
					if (receiving) begin
						mlen = (wr_ptr + 2 * RING_DEPTH - prefix_pos - 2) % RING_DEPTH;
						ring_bytes[prefix_pos] = mlen[7:0];
						ring_bytes[(prefix_pos + 1) % RING_DEPTH] = mlen[15:8];
						commit_ptr = wr_ptr;
						committed += 2 + mlen;
						receiving = 1'b0;
					end
					restart_check();
				end
				CMD_ROLLBACK: begin
					if (receiving) begin
						wr_ptr = commit_ptr;
						receiving = 1'b0;
					end
					restart_check();
				end
				CMD_CLEAR: begin
					wr_ptr = 0;
					commit_ptr = 0;
					rd_ptr = 0;
					committed = 0;
					receiving = 1'b0;
					held = 1'b0;
					pop_left = 0;
				end
				CMD_READ_REQ: begin
					length_set = 1'b1;
					if (pop_left == 0 && committed >= 2) begin
						mlen = 32'(next_length());
						if (mlen <= limit && committed >= 2 + mlen) begin
							st.accepted = 1'b1;
							st.message_length = mlen[15:0];
							rd_ptr = (rd_ptr + 2) % RING_DEPTH;
							committed -= 2;
							pop_left = mlen;
						end
					end
					if (held)
						restart_check();
				end
				CMD_READ_BYTE: begin
					if (pop_left != 0 && committed != 0) begin
						st.read_data = ring_bytes[rd_ptr];
						rd_ptr = (rd_ptr + 1) % RING_DEPTH;
						committed -= 1;
						pop_left -= 1;
						if (pop_left == 0) begin
							st.last_byte = 1'b1;
							if (held)
								restart_check();
						end
					end
				end
				default: ;
			endcase
			if (!length_set)
				st.message_length = next_length();
			st.endpoint_open = !held;
			st.stored_bytes = committed[15:0];
			pending_status.push_back(st);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				failures++;
				$display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_status(bit [47:0] tdata, bit tlast);
			out_item_t    got;
			ring_status_t want;
			got = tdata[OUT_ITEM_W-1:0];
			if (pending_status.size() == 0) begin
				failures++;
				$display("[%0t] status item with none pending: expected none, actual %h",
					$time, tdata);
				return;
			end
			want = pending_status.pop_front();
			compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
			compare_field("message_length", 32'(want.message_length),
				32'(got.message_length));
			compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
			compare_field("last_byte", 32'(want.last_byte), 32'(tlast));
			compare_field("endpoint_open", 32'(want.endpoint_open), 32'(got.endpoint_open));
			compare_field("stored_bytes", 32'(want.stored_bytes), 32'(got.stored_bytes));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	message_ring_checker ring_check;
	int unsigned         items_sent = 0;
	int unsigned         results_seen = 0;
	int unsigned         send_burst_left = 0;
	bit                  send_no_gap = 1'b0;
	int unsigned         idle_cycles = 0;

	framed_message_ring_commit_rollback_unit #(
		.RING_DEPTH(RING_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				ring_check.note_command(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				ring_check.check_status(m_axis_tdata, m_axis_tlast);
				results_seen++;
			end
		end
	end

	// Count cycles without any item moving on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no item moved for %0d cycles", $time, idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Reader side: random stalls, no-stall stretches and one long hold-off.
	initial begin
		int unsigned stall;
		int unsigned burst_left;
		bit          no_stall;
		bit          pressure_done;
		burst_left = 0;
		no_stall = 1'b0;
		pressure_done = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (burst_left == 0) begin
				no_stall = ($urandom_range(0, 3) == 0);
				burst_left = 32;
			end
			burst_left--;
			stall = no_stall ? 0 : $urandom_range(0, 8);
			if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
				stall = PRESSURE_CYCLES;
				pressure_done = 1'b1;
			end
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_item(bit [2:0] cmd, bit [31:0] size, bit [7:0] data_in,
		bit [15:0] limit);
		int unsigned gap;
		if (send_burst_left == 0) begin
			send_no_gap = ($urandom_range(0, 3) == 0);
			send_burst_left = 32;
		end
		send_burst_left--;
		gap = send_no_gap ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {5'b0, limit, data_in, size, cmd};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Write the threshold only once every status item has come back.
	task automatic set_threshold(bit [15:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (ring_check.pending_status.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ring_check.threshold = value;
	endtask

	function automatic bit [31:0] pick_transfer_size(int unsigned n);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return n;
		if (r < 85)
			return $urandom_range(0, 64);
		if (r < 95)
			return $urandom;
		return (r < 98) ? 32'hffff_ffff : 32'd0;
	endfunction

	function automatic int unsigned pick_message_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(0, 16);
		if (r < 95)
			return $urandom_range(17, 120);
		return $urandom_range(121, 400);
	endfunction

	task automatic send_message(int unsigned n);
		int unsigned r;
		send_item(CMD_START, pick_transfer_size(n), 8'd0, 16'd0);
		for (int unsigned i = 0; i < n; i++) begin
			if (i == n / 2 && $urandom_range(0, 9) == 0)
				send_item(CMD_START, pick_transfer_size(n - i), 8'd0, 16'd0);
			send_item(CMD_DATA, 32'd0, 8'($urandom_range(0, 255)), 16'd0);
		end
		r = $urandom_range(0, 99);
		if (r < 82)
			send_item(CMD_COMMIT, 32'd0, 8'd0, 16'd0);
		else if (r < 95)
			send_item(CMD_ROLLBACK, 32'd0, 8'd0, 16'd0);
	endtask

	task automatic receive_message();
		int unsigned r;
		int unsigned count;
		bit [15:0]   limit;
		r = $urandom_range(0, 99);
		if (r < 60)
			limit = 16'hffff;
		else if (r < 85)
			limit = 16'($urandom_range(0, 40));
		else
			limit = 16'($urandom_range(0, 65535));
		send_item(CMD_READ_REQ, 32'd0, 8'd0, limit);
		count = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 150) : $urandom_range(0, 24);
		repeat (count)
			send_item(CMD_READ_BYTE, 32'd0, 8'd0, 16'd0);
	endtask

	task automatic send_noise();
		bit [2:0] cmd;
		cmd = 3'($urandom_range(0, 7));
		// keep clears rare so the ring gets to fill up
		if (cmd == CMD_CLEAR && $urandom_range(0, 3) != 0)
			cmd = CMD_COMMIT;
		send_item(cmd, $urandom, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
	endtask

	task automatic run_random(int unsigned budget);
		int unsigned stop_at;
		int unsigned writer_share;
		stop_at = items_sent + budget;
		writer_share = 50;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 31) == 0)
				writer_share = $urandom_range(20, 85);
			if ($urandom_range(0, 99) < 10)
				send_noise();
			else if ($urandom_range(1, 100) <= writer_share)
				send_message(pick_message_length());
			else
				receive_message();
		end
	endtask

	task automatic run_directed();
		// idle reader and stray commands on an empty ring
		send_item(CMD_READ_BYTE, 32'd0, 8'd0, 16'd0);
		send_item(CMD_READ_REQ, 32'd0, 8'd0, 16'hffff);
		send_item(CMD_COMMIT, 32'd0, 8'd0, 16'd0);
		send_item(CMD_ROLLBACK, 32'd0, 8'd0, 16'd0);
		send_item(CMD_DATA, 32'd0, 8'hff, 16'd0);
		send_item(CMD_UNKNOWN, 32'hffff_ffff, 8'hff, 16'hffff);
		// message of three bytes with continuation starts
		send_item(CMD_START, 32'd3, 8'd0, 16'd0);
		send_item(CMD_START, 32'hffff_ffff, 8'd0, 16'd0);
		send_item(CMD_START, 32'd0, 8'd0, 16'd0);
		send_item(CMD_DATA, 32'd0, 8'h00, 16'd0);
		send_item(CMD_DATA, 32'd0, 8'hff, 16'd0);
		send_item(CMD_DATA, 32'd0, 8'ha5, 16'd0);
		send_item(CMD_COMMIT, 32'd0, 8'd0, 16'd0);
		// largest start that fits, then drop it
		send_item(CMD_START, 32'd1016, 8'd0, 16'd0);
		send_item(CMD_DATA, 32'd0, 8'h5a, 16'd0);
		send_item(CMD_ROLLBACK, 32'd0, 8'd0, 16'd0);
		// read against a short limit, then pop the message
		send_item(CMD_READ_REQ, 32'd0, 8'd0, 16'd2);
		send_item(CMD_READ_REQ, 32'd0, 8'd0, 16'd3);
		send_item(CMD_READ_REQ, 32'd0, 8'd0, 16'hffff);
		repeat (3)
			send_item(CMD_READ_BYTE, 32'd0, 8'd0, 16'd0);
		// empty message granted against a zero limit
		send_item(CMD_START, 32'd0, 8'd0, 16'd0);
		send_item(CMD_COMMIT, 32'd0, 8'd0, 16'd0);
		send_item(CMD_READ_REQ, 32'd0, 8'd0, 16'd0);
		send_item(CMD_CLEAR, 32'd0, 8'd0, 16'd0);
	endtask

	// Fill the ring to the last entry, drop the overflow, pop a few bytes, clear.
	task automatic fill_ring();
		send_item(CMD_CLEAR, 32'd0, 8'd0, 16'd0);
		send_item(CMD_START, 32'd0, 8'd0, 16'd0);
		repeat (RING_DEPTH + 1)
			send_item(CMD_DATA, 32'd0, 8'($urandom_range(0, 255)), 16'd0);
		send_item(CMD_COMMIT, 32'd0, 8'd0, 16'd0);
		send_item(CMD_READ_REQ, 32'd0, 8'd0, 16'hffff);
		repeat (20)
			send_item(CMD_READ_BYTE, 32'd0, 8'd0, 16'd0);
		send_item(CMD_CLEAR, 32'd0, 8'd0, 16'd0);
	endtask

	initial begin
		ring_check = new();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_threshold(16'd0);
				1: set_threshold(16'hffff);
				2: set_threshold(16'(RING_DEPTH - 1));
				3: set_threshold(16'($urandom_range(100, 900)));
				default: set_threshold(ACCEPT_RESET);
			endcase
			if (phase == 3)
				fill_ring();
			run_random(PHASE_ITEMS);
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (ring_check.pending_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ring_check.failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
